@@ sv/lrd_pkg.sv @@
// Package for the lift repetition detector.
// Shared widths, codes, controller states and the controller/datapath structs.
// No dependencies.
package lrd_pkg;

  localparam int SMOOTH_DEPTH = 3;
  localparam int SPEED_DEPTH  = 6;

  localparam int RFILL_W = $clog2(SMOOTH_DEPTH + 1);
  localparam int HFILL_W = $clog2(SPEED_DEPTH + 1);
  localparam int HIDX_W  = $clog2(SPEED_DEPTH);

  localparam int H_W    = 14;   // heights and lift
  localparam int SPD_W  = 25;   // speed
  localparam int NUM_W  = 26;   // signed divider numerator
  localparam int MAG_W  = 25;   // numerator magnitude
  localparam int DEN_W  = 31;   // divider denominator
  localparam int T_W    = 32;

  localparam logic [9:0]  SCALE_MS    = 10'd1000;
  localparam logic [5:0]  RETURN_BAND = 6'd25;
  localparam logic [31:0] TIMEOUT_MS  = 32'd500;

  localparam logic [1:0] KIND_READ    = 2'd0;
  localparam logic [1:0] KIND_TIMEOUT = 2'd1;
  localparam logic [1:0] KIND_CLEAR   = 2'd2;

  localparam logic [2:0] REG_BASELINE  = 3'd0;
  localparam logic [2:0] REG_START     = 3'd1;
  localparam logic [2:0] REG_HYST      = 3'd2;
  localparam logic [2:0] REG_MIN_RANGE = 3'd3;
  localparam logic [2:0] REG_MIN_REP   = 3'd4;
  localparam logic [2:0] REG_REST      = 3'd5;
  localparam logic [2:0] REG_MOVING    = 3'd6;
  localparam logic [2:0] REG_STILL     = 3'd7;

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_UP   = 2'd1,
    PH_DOWN = 2'd2
  } phase_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_RAW,
    S_SUM,
    S_DIV1,
    S_HIST,
    S_MUL,
    S_SPD,
    S_DIV2,
    S_PH1,
    S_PH2,
    S_MISC,
    S_OUT
  } ctrl_state_t;

  typedef struct packed {
    logic load_in;
    logic raw_shift;
    logic div_lift;
    logic take_lift;
    logic hist_shift;
    logic mul_step;
    logic div_speed;
    logic speed_zero;
    logic take_speed;
    logic ph_track;
    logic ph_decide;
    logic misc;
    logic out_load;
  } lrd_cmd_t;

  typedef struct packed {
    logic       div_done;
    logic       hist_ge2;
    logic       dt_ok;
    logic       hist_full;
    logic       out_free;
  } lrd_stat_t;

endpackage

@@ sv/lrd_div.sv @@
// Iterative signed-by-unsigned divider, one quotient bit per cycle.
// Truncates toward zero. Depends on lrd_pkg.
module lrd_div (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  input  logic signed [lrd_pkg::NUM_W-1:0] num,
  input  logic [lrd_pkg::DEN_W-1:0]       den,
  output logic                            done,
  output logic signed [lrd_pkg::NUM_W-1:0] quo
);
  localparam int CNT_W = $clog2(lrd_pkg::MAG_W + 1);

  logic [lrd_pkg::DEN_W:0]   rem_r, rem_nxt, rem_sh;
  logic [lrd_pkg::MAG_W-1:0] q_r, q_nxt;
  logic [lrd_pkg::DEN_W-1:0] den_r;
  logic                      neg_r;
  logic [CNT_W-1:0]          cnt_r, cnt_nxt;
  logic                      busy_r, busy_nxt, done_r, done_nxt;
  logic [lrd_pkg::NUM_W-1:0] abs_num;

  always_comb begin
    abs_num = num[lrd_pkg::NUM_W-1] ? -num : num;
    rem_sh  = {rem_r[lrd_pkg::DEN_W-1:0], q_r[lrd_pkg::MAG_W-1]};
    rem_nxt = rem_r;
    q_nxt   = q_r;
    cnt_nxt = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      rem_nxt  = '0;
      q_nxt    = abs_num[lrd_pkg::MAG_W-1:0];
      cnt_nxt  = CNT_W'(lrd_pkg::MAG_W);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (rem_sh >= {1'b0, den_r}) begin
        rem_nxt = rem_sh - {1'b0, den_r};
        q_nxt   = {q_r[lrd_pkg::MAG_W-2:0], 1'b1};
      end else begin
        rem_nxt = rem_sh;
        q_nxt   = {q_r[lrd_pkg::MAG_W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    q_r   <= q_nxt;
    if (start) begin
      den_r <= den;
      neg_r <= num[lrd_pkg::NUM_W-1];
    end
  end

  assign done = done_r;
  assign quo  = neg_r ? -$signed({1'b0, q_r}) : $signed({1'b0, q_r});
endmodule

@@ sv/lrd_dp.sv @@
// Datapath: config registers, smoothing and speed windows, motion tracking,
// output register. Depends on lrd_pkg and lrd_div.
module lrd_dp (
  input  logic                    clk,
  input  logic                    rst_n,
  input  lrd_pkg::lrd_cmd_t       cmd,
  output lrd_pkg::lrd_stat_t      stat,
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [2:0]              cfg_index,
  input  logic [15:0]             cfg_wdata,
  input  logic [1:0]              in_kind,
  input  logic [12:0]             in_distance_mm,
  input  logic [31:0]             in_time_ms,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic signed [13:0]      out_lift_mm,
  output logic signed [24:0]      out_speed,
  output logic [1:0]              out_motion_state,
  output logic                    out_rep_done,
  output logic [15:0]             out_rep_number,
  output logic [13:0]             out_range_of_motion,
  output logic [15:0]             out_rep_duration
);
  localparam int SD = lrd_pkg::SMOOTH_DEPTH;
  localparam int VD = lrd_pkg::SPEED_DEPTH;

  // configuration
  logic [12:0] baseline_r;
  logic [9:0]  start_r;
  logic [7:0]  hyst_r;
  logic [11:0] min_range_r;
  logic [15:0] min_rep_r, rest_cfg_r;
  logic [11:0] moving_r, still_r;

  // latched item
  logic [1:0]  kind_r;
  logic [12:0] dist_r;
  logic [31:0] time_r;

  // state
  logic signed [13:0] raw_win_r [SD];
  logic [lrd_pkg::RFILL_W-1:0] raw_fill_r;
  logic signed [13:0] hwin_r [VD];
  logic [31:0]        twin_r [VD];
  logic [lrd_pkg::HFILL_W-1:0] hfill_r;
  logic signed [13:0] lift_r, start_h_r, peak_r, valley_r;
  logic signed [24:0] speed_r;
  lrd_pkg::phase_t    phase_r;
  logic [31:0]        start_t_r, valley_t_r, rest_r, last_t_r;
  logic [15:0]        rep_cnt_r;
  logic               got_rep_r;
  logic [13:0]        got_rng_r;
  logic [15:0]        got_dur_r;
  logic signed [25:0] prod_r;
  logic [31:0]        dt_r;

  // output register
  logic               out_valid_r;
  logic signed [13:0] o_lift_r;
  logic signed [24:0] o_speed_r;
  logic [1:0]         o_phase_r;
  logic               o_done_r;
  logic [15:0]        o_num_r, o_dur_r;
  logic [13:0]        o_rng_r;

  // divider
  logic               div_start, div_done;
  logic signed [25:0] div_num, div_quo;
  logic [30:0]        div_den;

  logic signed [16:0] raw_sum;
  logic signed [13:0] raw_new;
  logic [lrd_pkg::HIDX_W-1:0] old_idx;
  logic signed [14:0] dh;
  logic signed [15:0] h_s, peak_s, valley_s, start_s, hyst_s;
  logic signed [24:0] mov_s, still_s, av;
  logic signed [14:0] rom;
  logic [31:0]        total;
  logic               rep_ok;
  logic               clear_all;

  assign cfg_ready = rst_n;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      baseline_r  <= 13'd0;
      start_r     <= 10'd20;
      hyst_r      <= 8'd10;
      min_range_r <= 12'd50;
      min_rep_r   <= 16'd400;
      rest_cfg_r  <= 16'd400;
      moving_r    <= 12'd40;
      still_r     <= 12'd25;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        lrd_pkg::REG_BASELINE:  baseline_r  <= cfg_wdata[12:0];
        lrd_pkg::REG_START:     start_r     <= cfg_wdata[9:0];
        lrd_pkg::REG_HYST:      hyst_r      <= cfg_wdata[7:0];
        lrd_pkg::REG_MIN_RANGE: min_range_r <= cfg_wdata[11:0];
        lrd_pkg::REG_MIN_REP:   min_rep_r   <= cfg_wdata;
        lrd_pkg::REG_REST:      rest_cfg_r  <= cfg_wdata;
        lrd_pkg::REG_MOVING:    moving_r    <= cfg_wdata[11:0];
        lrd_pkg::REG_STILL:     still_r     <= cfg_wdata[11:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      kind_r <= in_kind;
      dist_r <= in_distance_mm;
      time_r <= in_time_ms;
    end
  end

  always_comb begin
    raw_new = 14'($signed({1'b0, baseline_r}) - $signed({1'b0, dist_r}));
    raw_sum = '0;
    for (int i = 0; i < SD; i++) begin
      if (i < int'(raw_fill_r))
        raw_sum = raw_sum + 17'(raw_win_r[i]);
    end
    old_idx = lrd_pkg::HIDX_W'(hfill_r - 1'b1);
    dh      = 15'(hwin_r[0]) - 15'(hwin_r[old_idx]);

    h_s      = 16'(lift_r);
    peak_s   = 16'(peak_r);
    valley_s = 16'(valley_r);
    start_s  = $signed({6'd0, start_r});
    hyst_s   = $signed({8'd0, hyst_r});
    mov_s    = $signed({13'd0, moving_r});
    still_s  = $signed({13'd0, still_r});
    av       = speed_r[24] ? -speed_r : speed_r;

    rom    = 15'(peak_r) - 15'(start_h_r);
    total  = valley_t_r - start_t_r;
    rep_ok = !((rom < $signed({3'd0, min_range_r})) || (total < {16'd0, min_rep_r}));

    div_start = cmd.div_lift | cmd.div_speed;
    div_num   = cmd.div_lift ? 26'(raw_sum) : prod_r;
    div_den   = cmd.div_lift ? 31'(raw_fill_r) : dt_r[30:0];
    clear_all = cmd.misc && (kind_r == lrd_pkg::KIND_CLEAR);
  end

  lrd_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quo   (div_quo)
  );

  always_ff @(posedge clk) begin
    if (cmd.mul_step) begin
      prod_r <= 26'(dh * $signed({1'b0, lrd_pkg::SCALE_MS}));
      dt_r   <= twin_r[0] - twin_r[old_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || clear_all) begin
      for (int i = 0; i < SD; i++) raw_win_r[i] <= '0;
      for (int i = 0; i < VD; i++) begin
        hwin_r[i] <= '0;
        twin_r[i] <= '0;
      end
      raw_fill_r <= '0;
      hfill_r    <= '0;
      lift_r     <= '0;
      speed_r    <= '0;
      phase_r    <= lrd_pkg::PH_IDLE;
      start_h_r  <= '0;
      peak_r     <= '0;
      valley_r   <= '0;
      start_t_r  <= '0;
      valley_t_r <= '0;
      rest_r     <= '0;
      rep_cnt_r  <= '0;
      last_t_r   <= '0;
      got_rep_r  <= 1'b0;
      got_rng_r  <= '0;
      got_dur_r  <= '0;
    end else begin
      if (cmd.load_in) begin
        got_rep_r <= 1'b0;
        got_rng_r <= '0;
        got_dur_r <= '0;
      end
      if (cmd.raw_shift) begin
        last_t_r <= time_r;
        for (int i = SD - 1; i > 0; i--) raw_win_r[i] <= raw_win_r[i-1];
        raw_win_r[0] <= raw_new;
        if (raw_fill_r < lrd_pkg::RFILL_W'(SD)) raw_fill_r <= raw_fill_r + 1'b1;
      end
      if (cmd.take_lift) lift_r <= div_quo[13:0];
      if (cmd.hist_shift) begin
        for (int i = VD - 1; i > 0; i--) begin
          hwin_r[i] <= hwin_r[i-1];
          twin_r[i] <= twin_r[i-1];
        end
        hwin_r[0] <= lift_r;
        twin_r[0] <= time_r;
        if (hfill_r < lrd_pkg::HFILL_W'(VD)) hfill_r <= hfill_r + 1'b1;
      end
      if (cmd.speed_zero) speed_r <= '0;
      if (cmd.take_speed) speed_r <= div_quo[24:0];
      if (cmd.ph_track) begin
        if (phase_r == lrd_pkg::PH_UP) begin
          if (lift_r > peak_r) peak_r <= lift_r;
        end else if (phase_r == lrd_pkg::PH_DOWN) begin
          if (lift_r < valley_r) begin
            valley_r   <= lift_r;
            valley_t_r <= time_r;
          end
        end
      end
      if (cmd.ph_decide) begin
        unique case (phase_r)
          lrd_pkg::PH_IDLE: begin
            if (h_s > start_s && speed_r > mov_s) begin
              phase_r   <= lrd_pkg::PH_UP;
              start_h_r <= '0;
              peak_r    <= '0;
              start_t_r <= twin_r[VD-1];
            end
          end
          lrd_pkg::PH_UP: begin
            if (h_s < peak_s - hyst_s) begin
              phase_r    <= lrd_pkg::PH_DOWN;
              valley_t_r <= time_r;
              valley_r   <= lift_r;
              rest_r     <= '0;
            end
          end
          lrd_pkg::PH_DOWN: begin
            if (h_s > valley_s + hyst_s && speed_r > mov_s) begin
              if (rep_ok) begin
                if (rep_cnt_r != 16'hFFFF) rep_cnt_r <= rep_cnt_r + 1'b1;
                got_rep_r <= 1'b1;
                got_rng_r <= rom[13:0];
                got_dur_r <= (total > 32'hFFFF) ? 16'hFFFF : total[15:0];
              end
              phase_r   <= lrd_pkg::PH_UP;
              start_h_r <= valley_r;
              peak_r    <= valley_r;
              start_t_r <= valley_t_r;
            end else if (h_s < start_s + $signed({10'd0, lrd_pkg::RETURN_BAND})
                         && av < still_s) begin
              if (rest_r == 32'd0) begin
                rest_r <= time_r;
              end else if (time_r - rest_r > {16'd0, rest_cfg_r}) begin
                if (rep_ok) begin
                  if (rep_cnt_r != 16'hFFFF) rep_cnt_r <= rep_cnt_r + 1'b1;
                  got_rep_r <= 1'b1;
                  got_rng_r <= rom[13:0];
                  got_dur_r <= (total > 32'hFFFF) ? 16'hFFFF : total[15:0];
                end
                phase_r <= lrd_pkg::PH_IDLE;
                rest_r  <= '0;
              end
            end else begin
              rest_r <= '0;
            end
          end
          default: phase_r <= lrd_pkg::PH_IDLE;
        endcase
      end
      if (cmd.misc && kind_r == lrd_pkg::KIND_TIMEOUT) begin
        if (phase_r != lrd_pkg::PH_IDLE && (time_r - last_t_r) > lrd_pkg::TIMEOUT_MS)
          phase_r <= lrd_pkg::PH_IDLE;
      end
    end
  end

  // output stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      o_lift_r  <= lift_r;
      o_speed_r <= speed_r;
      o_phase_r <= phase_r;
      o_done_r  <= got_rep_r;
      o_num_r   <= rep_cnt_r;
      o_rng_r   <= got_rng_r;
      o_dur_r   <= got_dur_r;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_lift_mm         = o_lift_r;
  assign out_speed           = o_speed_r;
  assign out_motion_state    = o_phase_r;
  assign out_rep_done        = o_done_r;
  assign out_rep_number      = o_num_r;
  assign out_range_of_motion = o_rng_r;
  assign out_rep_duration    = o_dur_r;

  always_comb begin
    stat.div_done  = div_done;
    stat.hist_ge2  = hfill_r >= lrd_pkg::HFILL_W'(2);
    stat.dt_ok     = (dt_r != 32'd0) && !dt_r[31];
    stat.hist_full = hfill_r >= lrd_pkg::HFILL_W'(VD);
    stat.out_free  = !out_valid_r || out_ready;
  end
endmodule

@@ sv/lrd_ctrl.sv @@
// Controller: sequences one item through the datapath.
// Depends on lrd_pkg.
module lrd_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         in_kind,
  input  lrd_pkg::lrd_stat_t stat,
  output lrd_pkg::lrd_cmd_t  cmd
);
  lrd_pkg::ctrl_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= lrd_pkg::S_IDLE;
    else        state_r <= state_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      lrd_pkg::S_IDLE:
        if (in_valid) state_nxt = (in_kind == lrd_pkg::KIND_READ) ? lrd_pkg::S_RAW
                                                                  : lrd_pkg::S_MISC;
      lrd_pkg::S_RAW:  state_nxt = lrd_pkg::S_SUM;
      lrd_pkg::S_SUM:  state_nxt = lrd_pkg::S_DIV1;
      lrd_pkg::S_DIV1: if (stat.div_done) state_nxt = lrd_pkg::S_HIST;
      lrd_pkg::S_HIST: state_nxt = lrd_pkg::S_MUL;
      lrd_pkg::S_MUL:  state_nxt = lrd_pkg::S_SPD;
      lrd_pkg::S_SPD:
        if (stat.hist_ge2 && stat.dt_ok) state_nxt = lrd_pkg::S_DIV2;
        else if (stat.hist_full)         state_nxt = lrd_pkg::S_PH1;
        else                             state_nxt = lrd_pkg::S_OUT;
      lrd_pkg::S_DIV2:
        if (stat.div_done) state_nxt = stat.hist_full ? lrd_pkg::S_PH1 : lrd_pkg::S_OUT;
      lrd_pkg::S_PH1:  state_nxt = lrd_pkg::S_PH2;
      lrd_pkg::S_PH2:  state_nxt = lrd_pkg::S_OUT;
      lrd_pkg::S_MISC: state_nxt = lrd_pkg::S_OUT;
      lrd_pkg::S_OUT:  if (stat.out_free) state_nxt = lrd_pkg::S_IDLE;
      default:         state_nxt = lrd_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    unique case (state_r)
      lrd_pkg::S_IDLE: begin
        in_ready    = rst_n;
        cmd.load_in = in_valid && rst_n;
      end
      lrd_pkg::S_RAW:  cmd.raw_shift = 1'b1;
      lrd_pkg::S_SUM:  cmd.div_lift = 1'b1;
      lrd_pkg::S_DIV1: cmd.take_lift = stat.div_done;
      lrd_pkg::S_HIST: cmd.hist_shift = 1'b1;
      lrd_pkg::S_MUL:  cmd.mul_step = 1'b1;
      lrd_pkg::S_SPD: begin
        cmd.speed_zero = !stat.hist_ge2;
        cmd.div_speed  = stat.hist_ge2 && stat.dt_ok;
      end
      lrd_pkg::S_DIV2: cmd.take_speed = stat.div_done;
      lrd_pkg::S_PH1:  cmd.ph_track = 1'b1;
      lrd_pkg::S_PH2:  cmd.ph_decide = 1'b1;
      lrd_pkg::S_MISC: cmd.misc = 1'b1;
      lrd_pkg::S_OUT:  cmd.out_load = stat.out_free;
      default: ;
    endcase
  end
endmodule

@@ sv/lift_rep_detector_core.sv @@
// Each reading goes through two divisions, lift and speed, in one shared bit-serial
// divider; the speed division is skipped when the speed window holds fewer than two
// readings or the window time is not positive. Other items bypass the divider.
// Items are handled one at a time; the next can be accepted in the idle state that
// follows the result entering the output register, and a stalled result holds it.
// Synchronous active-low reset clears the controller, tracking state and output valid, and loads register defaults.
module lift_rep_detector_core (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [15:0]        cfg_wdata,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         in_kind,
  input  logic [12:0]        in_distance_mm,
  input  logic [31:0]        in_time_ms,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [13:0] out_lift_mm,
  output logic signed [24:0] out_speed,
  output logic [1:0]         out_motion_state,
  output logic               out_rep_done,
  output logic [15:0]        out_rep_number,
  output logic [13:0]        out_range_of_motion,
  output logic [15:0]        out_rep_duration
);
  lrd_pkg::lrd_cmd_t  cmd;
  lrd_pkg::lrd_stat_t stat;

  lrd_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_kind  (in_kind),
    .stat     (stat),
    .cmd      (cmd)
  );

  lrd_dp u_dp (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cmd                 (cmd),
    .stat                (stat),
    .cfg_valid           (cfg_valid),
    .cfg_ready           (cfg_ready),
    .cfg_index           (cfg_index),
    .cfg_wdata           (cfg_wdata),
    .in_kind             (in_kind),
    .in_distance_mm      (in_distance_mm),
    .in_time_ms          (in_time_ms),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_lift_mm         (out_lift_mm),
    .out_speed           (out_speed),
    .out_motion_state    (out_motion_state),
    .out_rep_done        (out_rep_done),
    .out_rep_number      (out_rep_number),
    .out_range_of_motion (out_range_of_motion),
    .out_rep_duration    (out_rep_duration)
  );
endmodule

@@ test/lift_rep_detector_core_tb.sv @@
// Testbench for lift_rep_detector_core: drives readings, timeouts and clears,
// predicts each per-item report with a behavioral tracker and checks them in order.
// Depends on lrd_pkg and the lift_rep_detector_core RTL.
module lift_rep_detector_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 900000;
  localparam int DRAIN_CYCLES = 80;
  localparam int SD = lrd_pkg::SMOOTH_DEPTH;
  localparam int VD = lrd_pkg::SPEED_DEPTH;
  localparam logic [1:0] KIND_UNUSED = 2'd3;

  typedef struct packed {
    logic signed [13:0] lift;
    logic signed [24:0] speed;
    logic [1:0]         state;
    logic               done;
    logic [15:0]        number;
    logic [13:0]        rom;
    logic [15:0]        duration;
  } rep_report_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [2:0] cfg_index = '0;
  logic [15:0] cfg_wdata = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [1:0] in_kind = '0;
  logic [12:0] in_distance_mm = '0;
  logic [31:0] in_time_ms = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [13:0] out_lift_mm;
  logic signed [24:0] out_speed;
  logic [1:0] out_motion_state;
  logic out_rep_done;
  logic [15:0] out_rep_number;
  logic [13:0] out_range_of_motion;
  logic [15:0] out_rep_duration;

  lift_rep_detector_core DUT (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // tracker configuration
  int c_base, c_start, c_hyst, c_minr, c_moving, c_still;
  logic [31:0] c_minrep, c_rest;
  // tracker state
  int raw_w[SD];
  int raw_n;
  int hgt_w[VD];
  logic [31:0] tim_w[VD];
  int hist_n;
  int lift_s, spd;
  lrd_pkg::phase_t ph;
  int st_h, pk_h, vl_h;
  logic [31:0] st_t, vl_t, rest_t, last_t;
  int reps;
  logic got_rep;
  int got_rom;
  logic [31:0] got_dur;

  rep_report_t expected_reports[$];
  int errors = 0;
  int cycles = 0;
  int items_sent = 0;
  int burst_left = 0;
  logic [31:0] t_now;

  function automatic void clear_tracker();
    for (int i = 0; i < SD; i++) raw_w[i] = 0;
    for (int i = 0; i < VD; i++) begin
      hgt_w[i] = 0;
      tim_w[i] = '0;
    end
    raw_n = 0; hist_n = 0; lift_s = 0; spd = 0; ph = lrd_pkg::PH_IDLE;
    st_h = 0; pk_h = 0; vl_h = 0; st_t = '0; vl_t = '0; rest_t = '0;
    reps = 0; last_t = '0;
  endfunction

  function automatic void start_lift(int h, logic [31:0] t);
    ph = lrd_pkg::PH_UP; st_h = h; st_t = t; pk_h = h;
  endfunction

  function automatic void close_rep(logic [31:0] t_end);
    int rom;
    logic [31:0] total;
    rom = pk_h - st_h;
    total = t_end - st_t;
    if (rom < c_minr || total < c_minrep) return;
    if (reps < 65535) reps++;
    got_rep = 1'b1;
    got_rom = rom;
    got_dur = (total > 32'd65535) ? 32'd65535 : total;
  endfunction

  function automatic void track_reading(int dist_mm, logic [31:0] now);
    int sum, old, h, v, av;
    logic [31:0] dt;
    sum = 0;
    last_t = now;
    for (int i = SD - 1; i > 0; i--) raw_w[i] = raw_w[i-1];
    raw_w[0] = c_base - dist_mm;
    if (raw_n < SD) raw_n++;
    for (int i = 0; i < raw_n; i++) sum += raw_w[i];
    lift_s = sum / raw_n;
    for (int i = VD - 1; i > 0; i--) begin
      hgt_w[i] = hgt_w[i-1];
      tim_w[i] = tim_w[i-1];
    end
    hgt_w[0] = lift_s;
    tim_w[0] = now;
    if (hist_n < VD) hist_n++;
    if (hist_n >= 2) begin
      old = hist_n - 1;
      dt = tim_w[0] - tim_w[old];
      // non-positive window time keeps the old speed
      if (dt >= 32'd1 && dt <= 32'h7FFF_FFFF)
        spd = (1000 * (hgt_w[0] - hgt_w[old])) / $signed(dt);
    end else begin
      spd = 0;
    end
    if (hist_n < VD) return;
    h = lift_s;
    v = spd;
    if (ph == lrd_pkg::PH_IDLE) begin
      if (h > c_start && v > c_moving) start_lift(0, tim_w[hist_n-1]);
    end else if (ph == lrd_pkg::PH_UP) begin
      if (h > pk_h) pk_h = h;
      if (h < pk_h - c_hyst) begin
        ph = lrd_pkg::PH_DOWN; vl_t = now; vl_h = h; rest_t = '0;
      end
    end else begin
      av = (v < 0) ? -v : v;
      if (h < vl_h) begin
        vl_h = h; vl_t = now;
      end
      if (h > vl_h + c_hyst && v > c_moving) begin
        close_rep(vl_t);
        start_lift(vl_h, vl_t);
        return;
      end
      if (h < c_start + 25 && av < c_still) begin
        if (rest_t == 32'd0) rest_t = now;
        else if (now - rest_t > c_rest) begin
          close_rep(vl_t);
          ph = lrd_pkg::PH_IDLE;
          rest_t = '0;
        end
      end else begin
        rest_t = '0;
      end
    end
  endfunction

  function automatic rep_report_t predict_report(logic [1:0] kind, int dist_mm,
                                                 logic [31:0] now);
    rep_report_t r;
    got_rep = 1'b0; got_rom = 0; got_dur = '0;
    if (kind == lrd_pkg::KIND_READ) track_reading(dist_mm, now);
    else if (kind == lrd_pkg::KIND_TIMEOUT) begin
      if (ph != lrd_pkg::PH_IDLE && now - last_t > lrd_pkg::TIMEOUT_MS)
        ph = lrd_pkg::PH_IDLE;
    end else if (kind == lrd_pkg::KIND_CLEAR) clear_tracker();
    r.lift = lift_s[13:0];
    r.speed = spd[24:0];
    r.state = ph;
    r.done = got_rep;
    r.number = reps[15:0];
    r.rom = got_rom[13:0];
    r.duration = got_dur[15:0];
    return r;
  endfunction

  // sender: bursts of random length separated by random gaps
  task automatic send_item(logic [1:0] kind, int dist_mm, logic [31:0] now);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        @(negedge clk) in_valid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
    burst_left--;
    @(negedge clk);
    in_valid <= 1'b1;
    in_kind <= kind;
    in_distance_mm <= dist_mm[12:0];
    in_time_ms <= now;
    do @(posedge clk); while (!in_ready);
    expected_reports.push_back(predict_report(kind, dist_mm & 13'h1FFF, now));
    items_sent++;
  endtask

  task automatic drain();
    @(negedge clk) in_valid <= 1'b0;
    while (expected_reports.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic cfg_write(logic [2:0] idx, int val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val[15:0];
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      lrd_pkg::REG_BASELINE:  c_base = val & 32'h1FFF;
      lrd_pkg::REG_START:     c_start = val & 32'h3FF;
      lrd_pkg::REG_HYST:      c_hyst = val & 32'hFF;
      lrd_pkg::REG_MIN_RANGE: c_minr = val & 32'hFFF;
      lrd_pkg::REG_MIN_REP:   c_minrep = val & 32'hFFFF;
      lrd_pkg::REG_REST:      c_rest = val & 32'hFFFF;
      lrd_pkg::REG_MOVING:    c_moving = val & 32'hFFF;
      lrd_pkg::REG_STILL:     c_still = val & 32'hFFF;
      default: ;
    endcase
    @(negedge clk) cfg_valid <= 1'b0;
  endtask

  task automatic cfg_all(int base, int st, int hy, int mr, int mrep, int rest, int mv, int sl);
    cfg_write(lrd_pkg::REG_BASELINE, base);
    cfg_write(lrd_pkg::REG_START, st);
    cfg_write(lrd_pkg::REG_HYST, hy);
    cfg_write(lrd_pkg::REG_MIN_RANGE, mr);
    cfg_write(lrd_pkg::REG_MIN_REP, mrep);
    cfg_write(lrd_pkg::REG_REST, rest);
    cfg_write(lrd_pkg::REG_MOVING, mv);
    cfg_write(lrd_pkg::REG_STILL, sl);
  endtask

  task automatic read_lift(int lift, int noise);
    int d;
    d = c_base - lift + ((noise > 0) ? $urandom_range(0, 2 * noise) - noise : 0);
    if (d < 0) d = 0;
    if (d > 8191) d = 8191;
    t_now += $urandom_range(15, 25);
    send_item(lrd_pkg::KIND_READ, d, t_now);
  endtask

  // one rise-fall cycle; rebound leaves the valley before settling
  task automatic lift_cycle(int amp, int up_n, int down_n, int rest_n, bit rebound, int noise);
    int valley;
    valley = rebound ? amp / 4 : 0;
    for (int k = 1; k <= up_n; k++) read_lift(amp * k / up_n, noise);
    for (int k = 1; k <= down_n; k++) read_lift(amp - (amp - valley) * k / down_n, noise);
    for (int k = 0; k < rest_n; k++) read_lift(valley, noise);
  endtask

  task automatic test_directed();
    send_item(KIND_UNUSED, 13'h1FFF, 32'hFFFF_FFFF);
    send_item(lrd_pkg::KIND_TIMEOUT, 0, 32'd0);
    send_item(lrd_pkg::KIND_READ, 0, 32'd0);      // reading at time zero, baseline 0
    send_item(lrd_pkg::KIND_READ, 8191, 32'd0);   // same time: no speed update
    send_item(lrd_pkg::KIND_READ, 4000, 32'd5);
    send_item(lrd_pkg::KIND_READ, 100, 32'd3);    // time going backwards
    send_item(lrd_pkg::KIND_CLEAR, 8191, 32'd0);
    drain();
    cfg_write(lrd_pkg::REG_BASELINE, 3000);
    t_now = 32'd0;
    for (int k = 0; k < 6; k++) read_lift(0, 0);
    lift_cycle(300, 6, 6, 0, 1'b1, 0);
    lift_cycle(300, 6, 6, 0, 1'b0, 0);
    send_item(lrd_pkg::KIND_TIMEOUT, 0, t_now + 32'd501);
    send_item(lrd_pkg::KIND_CLEAR, 0, t_now);
  endtask

  task automatic test_rest_and_wrap();
    t_now = 32'hFFFF_FF00;
    for (int k = 0; k < 6; k++) read_lift(0, 0);
    lift_cycle(400, 8, 8, 30, 1'b0, 2);
    lift_cycle(250, 5, 5, 0, 1'b1, 2);
    send_item(lrd_pkg::KIND_TIMEOUT, 0, t_now + 32'd400);
    send_item(lrd_pkg::KIND_TIMEOUT, 0, t_now + 32'd9000);
    drain();
  endtask

  task automatic test_extreme_settings();
    cfg_all(0, 0, 0, 0, 0, 0, 0, 0);
    t_now = $urandom;
    for (int k = 0; k < 40; k++) begin
      t_now += $urandom_range(0, 30);
      send_item(lrd_pkg::KIND_READ, $urandom_range(0, 8191), t_now);
    end
    drain();
    cfg_all(8191, 1023, 255, 4095, 65535, 65535, 4095, 4095);
    for (int k = 0; k < 40; k++) begin
      t_now += $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(1, 30);
      send_item(lrd_pkg::KIND_READ, $urandom_range(0, 8191), t_now);
    end
    lift_cycle(2000, 4, 4, 4, 1'b0, 0);
    drain();
  endtask

  task automatic test_random_traffic();
    int pick;
    while (items_sent < 800) begin
      if (items_sent % 200 < 30 && $urandom_range(0, 3) == 0) begin
        drain();
        cfg_all($urandom_range(2500, 8191), $urandom_range(0, 60), $urandom_range(0, 30),
                $urandom_range(0, 200), $urandom_range(0, 800), $urandom_range(0, 600),
                $urandom_range(0, 120), $urandom_range(0, 80));
      end
      pick = $urandom_range(0, 99);
      if (pick < 70)
        lift_cycle($urandom_range(30, 2000), $urandom_range(3, 15), $urandom_range(3, 15),
                   $urandom_range(0, 35), $urandom_range(0, 1), $urandom_range(0, 5));
      else if (pick < 85) begin
        t_now += ($urandom_range(0, 7) == 0) ? $urandom : $urandom_range(0, 40);
        send_item(lrd_pkg::KIND_READ, $urandom_range(0, 8191), t_now);
      end else if (pick < 93)
        send_item(lrd_pkg::KIND_TIMEOUT, $urandom_range(0, 8191),
                  t_now + $urandom_range(0, 1200));
      else if (pick < 97)
        send_item(lrd_pkg::KIND_CLEAR, $urandom_range(0, 8191), $urandom);
      else
        send_item(KIND_UNUSED, $urandom_range(0, 8191), $urandom);
    end
  endtask

  // receiver stall pattern
  int stall_left = 0;
  int stall_mode = 0;
  int stall_tick = 0;
  always @(negedge clk) begin
    if (stall_left == 0) begin
      stall_mode = $urandom_range(0, 3);
      stall_left = $urandom_range(20, 300);
    end
    stall_left--;
    stall_tick++;
    case (stall_mode)
      0: out_ready <= 1'b1;
      1: out_ready <= $urandom_range(0, 1);
      2: out_ready <= ($urandom_range(0, 3) == 0);
      default: out_ready <= (stall_tick % 8 != 0);
    endcase
  end

  always @(posedge clk) begin
    rep_report_t exp_r, got_r;
    if (rst_n && out_valid && out_ready) begin
      got_r = '{out_lift_mm, out_speed, out_motion_state, out_rep_done, out_rep_number,
                out_range_of_motion, out_rep_duration};
      if (expected_reports.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected report transaction: %p", got_r);
      end else begin
        exp_r = expected_reports.pop_front();
        if (got_r !== exp_r) begin
          errors++;
          if (errors <= 10) $display("mismatch: expected %p actual %p", exp_r, got_r);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("lift_rep_detector_core_tb NOT OK");
      $finish;
    end
  end

  initial begin
    c_base = 0; c_start = 20; c_hyst = 10; c_minr = 50;
    c_minrep = 32'd400; c_rest = 32'd400; c_moving = 40; c_still = 25;
    clear_tracker();
    t_now = '0;
    repeat (6) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;
    test_directed();
    test_rest_and_wrap();
    test_extreme_settings();
    cfg_all(3000, 20, 10, 50, 400, 400, 40, 25);
    test_random_traffic();
    drain();
    if (expected_reports.size() != 0) errors++;
    if (errors == 0) $display("lift_rep_detector_core_tb OK");
    else $display("lift_rep_detector_core_tb NOT OK");
    $finish;
  end

endmodule

@@ files.f @@
sv/lrd_pkg.sv
sv/lrd_div.sv
sv/lrd_dp.sv
sv/lrd_ctrl.sv
sv/lift_rep_detector_core.sv
test/lift_rep_detector_core_tb.sv
